// ===== rtl/core/bitmap_id_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap ID allocator
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define BIA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define BIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/bia_pkg.sv =====
// ----------------------------------------------------------------------------
// bia_pkg
// Sizes, codes and transaction types shared by the bitmap ID allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

	localparam int MAX_ENTRIES   = 4096;
	localparam int MAP_WORD_BITS = 32;
	localparam int MAP_WORDS     = (MAX_ENTRIES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WORD_AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W         = $clog2(MAP_WORD_BITS);
	localparam int USED_W        = $clog2(MAX_ENTRIES + 1);

	localparam int TOTAL_W = 13;
	localparam int NUM_W   = 12;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
	localparam logic [NUM_W-1:0]   NUM_MAX     = 12'hFFF;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_MARK  = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_FREE = 2'd1;
	localparam logic [1:0] STAT_RANGE   = 2'd2;
	localparam logic [1:0] STAT_NO_CHG  = 2'd3;

	typedef struct packed {
		logic [1:0]       action;
		logic [NUM_W-1:0] entry_number;
	} req_t;

	typedef struct packed {
		logic [NUM_W-1:0] granted_number;
		logic             is_set;
		logic [1:0]       status;
		logic [NUM_W-1:0] used_count;
	} rsp_t;

endpackage

// ===== rtl/core/bitmap_id_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator_top
// First-fit bitmap allocator over entry numbers 1 to entry_total-1, capped at 4095.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (action, entry_number) and each produces
// exactly one transaction on the rsp channel. Both channels use valid/stall.
// The user must write the entry_total register through cfg_wr_en/cfg_wr_data
// only while idle; the block itself does not enforce this. The map lives in
// a 128 x 32 RAM with a registered read port; one word is read and tested per
// cycle by a single find-first-clear unit. Allocate walks the map words in
// order until a clear bit turns up or the last word below the limit is
// tested. Free, query and mark read the word, test and write it, then load
// the output register; an out-of-range number goes straight to that load.
// One request is processed at a time; req_stall is high while it is.
// A finished response sits in the output register; the next request may be
// accepted meanwhile, and its result waits until the receiver drops rsp_stall.
// Reset clears all per-word valid bits at once, so the whole map reads as
// free right after reset with no clearing sweep. The allocated count is
// cleared and entry_total returns to 4096.
// ----------------------------------------------------------------------------
`include "bitmap_id_allocator_top_macros.svh"

module bitmap_id_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bia_pkg::TOTAL_W-1:0]  cfg_wr_data,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  bia_pkg::req_t                req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output bia_pkg::rsp_t                rsp
);

	localparam int BITS = bia_pkg::MAP_WORD_BITS;
	localparam int AW   = bia_pkg::WORD_AW;
	localparam int BW   = bia_pkg::BIT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SINGLE, ST_OUT} state_t;

	state_t                           state_q;
	logic [bia_pkg::TOTAL_W-1:0]      total_q;
	logic [bia_pkg::USED_W-1:0]       used_q;
	logic [bia_pkg::MAP_WORDS-1:0]    wvalid_q;
	logic [AW-1:0]                    ev_w_q;
	logic [BW-1:0]                    bit_q;
	logic [1:0]                       act_q;
	logic [bia_pkg::NUM_W-1:0]        res_grant_q;
	logic                             res_set_q;
	logic [1:0]                       res_stat_q;
	logic                             rsp_valid_q;
	bia_pkg::rsp_t                    rsp_q;

	logic [bia_pkg::TOTAL_W-1:0]      lim;
	logic [bia_pkg::TOTAL_W-1:0]      lim_w;
	logic [BW-1:0]                    lim_b;
	logic [AW-1:0]                    last_w;
	logic                             in_range;
	logic [BITS-1:0]                  word_mask;
	logic [BITS-1:0]                  eff;
	logic [BITS-1:0]                  free_vec;
	logic [BITS-1:0]                  low;
	logic [BW-1:0]                    idx;
	logic                             found;
	logic                             cur;
	logic [BITS-1:0]                  onehot;
	logic                             ram_we;
	logic [BITS-1:0]                  ram_wr_data;
	logic [AW-1:0]                    ram_rd_addr;
	logic [BITS-1:0]                  ram_rd_data;
	logic                             req_acc;
	logic [bia_pkg::NUM_W-1:0]        used_sat;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		if (32'(total_q) > bia_pkg::MAX_ENTRIES) begin
			lim = bia_pkg::TOTAL_W'(bia_pkg::MAX_ENTRIES);
		end else begin
			lim = total_q;
		end
		lim_w    = lim >> BW;
		lim_b    = lim[BW-1:0];
		last_w   = AW'((lim - 1'b1) >> BW);
		in_range = (req.entry_number != '0) && ({1'b0, req.entry_number} < lim);

		// Valid bits of the word under test: numbers below the limit, never 0.
		if (32'(ev_w_q) < 32'(lim_w)) begin
			word_mask = '1;
		end else if (32'(ev_w_q) == 32'(lim_w)) begin
			word_mask = ~({BITS{1'b1}} << lim_b);
		end else begin
			word_mask = '0;
		end
		if (ev_w_q == '0) begin
			word_mask[0] = 1'b0;
		end

		eff      = wvalid_q[ev_w_q] ? ram_rd_data : '0;
		free_vec = ~eff & word_mask;
		low      = free_vec & (~free_vec + 1'b1);
		found    = (free_vec != '0);
		idx      = '0;
		for (int j = 0; j < BITS; j++) begin
			idx = idx | (low[j] ? BW'(j) : '0);
		end

		onehot = BITS'(1) << bit_q;
		cur    = eff[bit_q];

		ram_we      = 1'b0;
		ram_wr_data = eff;
		unique case (state_q)
			ST_SCAN: begin
				ram_we      = found;
				ram_wr_data = eff | low;
			end
			ST_SINGLE: begin
				if (act_q == bia_pkg::ACT_FREE) begin
					ram_we      = cur;
					ram_wr_data = eff & ~onehot;
				end else if (act_q == bia_pkg::ACT_MARK) begin
					ram_we      = !cur;
					ram_wr_data = eff | onehot;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase

		if (state_q == ST_IDLE) begin
			if (req.action == bia_pkg::ACT_ALLOC) begin
				ram_rd_addr = '0;
			end else begin
				ram_rd_addr = AW'(req.entry_number >> BW);
			end
		end else begin
			ram_rd_addr = ev_w_q + 1'b1;
		end

		if (32'(used_q) > 32'(bia_pkg::NUM_MAX)) begin
			used_sat = bia_pkg::NUM_MAX;
		end else begin
			used_sat = bia_pkg::NUM_W'(used_q);
		end
	end

	bia_ram #(
		.WIDTH (BITS),
		.DEPTH (bia_pkg::MAP_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ev_w_q),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= bia_pkg::TOTAL_RESET;
			used_q      <= '0;
			wvalid_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			// In ST_OUT the output register is reloaded below instead.
			if (rsp_valid_q && !rsp_stall && (state_q != ST_OUT)) begin
				rsp_valid_q <= 1'b0;
			end
			if (ram_we) begin
				wvalid_q[ev_w_q] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						act_q       <= req.action;
						bit_q       <= req.entry_number[BW-1:0];
						res_grant_q <= '0;
						res_set_q   <= 1'b0;
						res_stat_q  <= bia_pkg::STAT_OK;
						if (req.action == bia_pkg::ACT_ALLOC) begin
							ev_w_q <= '0;
							if (lim <= bia_pkg::TOTAL_W'(1)) begin
								res_stat_q <= bia_pkg::STAT_NO_FREE;
								state_q    <= ST_OUT;
							end else begin
								state_q <= ST_SCAN;
							end
						end else begin
							ev_w_q <= AW'(req.entry_number >> BW);
							if (in_range) begin
								state_q <= ST_SINGLE;
							end else begin
								res_stat_q <= bia_pkg::STAT_RANGE;
								state_q    <= ST_OUT;
							end
						end
					end
				end
				ST_SCAN: begin
					// The read for the following word is already in flight.
					if (found) begin
						used_q      <= used_q + 1'b1;
						res_grant_q <= bia_pkg::NUM_W'((32'(ev_w_q) << BW) | 32'(idx));
						state_q     <= ST_OUT;
					end else if (ev_w_q == last_w) begin
						res_stat_q <= bia_pkg::STAT_NO_FREE;
						state_q    <= ST_OUT;
					end else begin
						ev_w_q <= ev_w_q + 1'b1;
					end
				end
				ST_SINGLE: begin
					state_q <= ST_OUT;
					case (act_q)
						bia_pkg::ACT_FREE: begin
							if (cur) begin
								if (used_q != '0) begin
									used_q <= used_q - 1'b1;
								end
							end else begin
								res_stat_q <= bia_pkg::STAT_NO_CHG;
							end
						end
						bia_pkg::ACT_MARK: begin
							if (!cur) begin
								used_q <= used_q + 1'b1;
							end else begin
								res_stat_q <= bia_pkg::STAT_NO_CHG;
							end
						end
						default: begin
							res_set_q <= cur;
						end
					endcase
				end
				ST_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q          <= 1'b1;
						rsp_q.granted_number <= res_grant_q;
						rsp_q.is_set         <= res_set_q;
						rsp_q.status         <= res_stat_q;
						rsp_q.used_count     <= used_sat;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BIA_ASSERT_NOW(a_grant_ok, clk, arst_n, rsp_valid && (rsp.granted_number != '0), rsp.status == bia_pkg::STAT_OK)
	`BIA_ASSERT_NOW(a_we_busy, clk, arst_n, ram_we, (state_q == ST_SCAN) || (state_q == ST_SINGLE))
	`BIA_ASSERT_NEXT(a_used_hold, clk, arst_n, !ram_we, $stable(used_q))

endmodule

// ===== rtl/core/bia_ram.sv =====
// ----------------------------------------------------------------------------
// bia_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
